// ===== rtl/assert_macros.svh =====
// Assertion helpers for the block checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define MWSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mwss assertion failed");

// check on every rising edge, reset included
`define MWSS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mwss assertion failed");

`endif

// ===== rtl/mwss_pkg.sv =====
package mwss_pkg;

  localparam int unsigned MAX_CITIES_DEF  = 16;
  localparam int unsigned MAX_PICK_DEF    = 16;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 5;
  localparam int unsigned ROW_W     = 4;
  localparam int unsigned WGT_W     = 16;
  localparam int unsigned BEST_W    = 24;
  localparam int unsigned SUM_W     = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_COUNT = 2'd1;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [BEST_W-1:0] SUM_LIMIT = {BEST_W{1'b1}};
  localparam logic [SUM_W-1:0]  NO_SUM    = {SUM_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_ROWNXT,
    ST_EVAL,
    ST_SCAN,
    ST_INC,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic init;
    logic rot;
    logic ccopy;
    logic crot;
  } cell_ctl_t;

endpackage

// ===== rtl/mwss_if.sv =====
interface mwss_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [mwss_pkg::ROW_W-1:0]   row;
  logic [mwss_pkg::ROW_W-1:0]   col;
  logic [mwss_pkg::WGT_W-1:0]   weight;
  modport source (output valid, func, row, col, weight, input ready);
  modport sink   (input valid, func, row, col, weight, output ready);
endinterface

interface mwss_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mwss_pkg::SUM_W-1:0] best_sum;
  logic                              found;
  modport source (output valid, best_sum, found, input ready);
  modport sink   (input valid, best_sum, found, output ready);
endinterface

interface mwss_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mwss_pkg::CFG_IDX_W-1:0] index;
  logic [mwss_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mwss_cell.sv =====
module mwss_cell #(
  parameter int unsigned CW = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mwss_pkg::cell_ctl_t ctl_i,
  input  logic                ld_i,
  input  logic [CW-1:0]       init_val_i,
  input  logic                init_act_i,
  input  logic [CW-1:0]       ld_val_i,
  input  logic [CW-1:0]       nb_city_i,
  input  logic                nb_act_i,
  input  logic [CW-1:0]       nb_col_i,
  input  logic                nb_cact_i,
  output logic [CW-1:0]       city_o,
  output logic                act_o,
  output logic [CW-1:0]       col_o,
  output logic                cact_o
);

  logic [CW-1:0] city_q, city_d, col_q, col_d;
  logic          act_q, act_d, cact_q, cact_d;

  always_comb begin
    city_d = city_q;
    act_d  = act_q;
    col_d  = col_q;
    cact_d = cact_q;
    if (ctl_i.init) begin
      city_d = init_val_i;
      act_d  = init_act_i;
    end else if (ld_i) begin
      city_d = ld_val_i;
    end else if (ctl_i.rot) begin
      city_d = nb_city_i;
      act_d  = nb_act_i;
    end
    if (ctl_i.ccopy) begin
      col_d  = city_q;
      cact_d = act_q;
    end else if (ctl_i.crot) begin
      col_d  = nb_col_i;
      cact_d = nb_cact_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      cact_q <= 1'b0;
    end else begin
      act_q  <= act_d;
      cact_q <= cact_d;
    end
  end

  always_ff @(posedge clk_i) begin
    city_q <= city_d;
    col_q  <= col_d;
  end

  assign city_o = city_q;
  assign act_o  = act_q;
  assign col_o  = col_q;
  assign cact_o = cact_q;

endmodule

// ===== rtl/max_weight_subset_search.sv =====
// Maximum-weight subset search over a square weight matrix.
// Input channel in_i: func 0 writes weight at (row, col) and is taken while
// idle; func 1 starts a search and in_i.ready stays low until it ends.
// Config channel cfg_i is always ready: index 0 city_count, 1 pick_count.
// A search walks every increasing choice of pick_count cities out of
// city_count. A row of MAX_PICK cells holds the choice; the cells rotate it
// past a head cell, and a second rotation inside each row streams the
// column cities past the head, one matrix read per cycle through a single
// read port. After each choice is summed, the block steps to the next one.
// A search with no valid choice goes from idle to done with found 0 and
// best_sum -1. One result item per search leaves on out_o from an output
// register; while out_o stalls, matrix writes are still taken and a new
// search runs, holding its result until the register frees.
// Reset sets city_count 16, pick_count 2 and clears all control state; the
// weight matrix is not cleared and must be written before it is read.
module max_weight_subset_search #(
  parameter int unsigned MAX_CITIES  = mwss_pkg::MAX_CITIES_DEF,
  parameter int unsigned MAX_PICK    = mwss_pkg::MAX_PICK_DEF,
  parameter int unsigned WEIGHT_BITS = mwss_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mwss_in_if.sink     in_i,
  mwss_cfg_if.sink    cfg_i,
  mwss_out_if.source  out_o
);

  localparam int unsigned CW   = $clog2(MAX_CITIES);
  localparam int unsigned PW   = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int unsigned KW   = $clog2(MAX_PICK + 1);
  localparam int unsigned CNW  = $clog2(MAX_CITIES + 1);
  localparam int unsigned MX1  = (CNW > KW) ? CNW : KW;
  localparam int unsigned MX2  = (MX1 > CW) ? MX1 : CW;
  localparam int unsigned SW   = MX2 + 1;
  localparam int unsigned MX3  = (MX1 > mwss_pkg::CFG_DAT_W) ? MX1 : mwss_pkg::CFG_DAT_W;
  localparam int unsigned CMPW = MX3 + 1;
  localparam int unsigned AW   = $clog2(MAX_PICK * MAX_PICK) + WEIGHT_BITS;
  localparam int unsigned EW   = (AW > mwss_pkg::BEST_W) ? AW : mwss_pkg::BEST_W;

  mwss_pkg::state_e state_q, state_d;

  logic [mwss_pkg::CFG_DAT_W-1:0] city_cnt_q, pick_cnt_q;

  logic [CNW-1:0] n_q, n_d;
  logic [KW-1:0]  k_q, k_d;
  logic [KW-1:0]  rstep_q, rstep_d, cstep_q, cstep_d, ptr_q, ptr_d;
  logic [AW-1:0]  acc_q, acc_d;
  logic [mwss_pkg::BEST_W-1:0] best_q, best_d;
  logic           any_q, any_d;
  logic           rd_v_q, rd_v_d;
  logic [WEIGHT_BITS-1:0] rdata_q;
  logic [WEIGHT_BITS-1:0] mem_q [MAX_CITIES][MAX_CITIES];

  logic                           out_vld_q, out_vld_d;
  logic signed [mwss_pkg::SUM_W-1:0] out_sum_q, out_sum_d;
  logic                           out_fnd_q, out_fnd_d;

  mwss_pkg::cell_ctl_t ctl;
  mwss_pkg::cell_ctl_t ctl_int;
  logic                init_go;
  logic [MAX_PICK-1:0] ld_en;
  logic [CW-1:0]       ld_val;
  logic [PW-1:0]       rd_idx;

  logic [CW-1:0] city [MAX_PICK];
  logic [CW-1:0] col  [MAX_PICK];
  logic          act  [MAX_PICK];
  logic          cact [MAX_PICK];

  logic                  in_acc, wr_en, srch;
  logic [CMPW-1:0]       n_eff, k_cfg;
  logic                  no_choice;
  logic [EW-1:0]         acc_ext;
  logic [mwss_pkg::BEST_W-1:0] sat;
  logic [CW-1:0]         sel_city;
  logic [SW-1:0]         limit;

  for (genvar m = 0; m < MAX_PICK; m++) begin : g_cell
    localparam int unsigned NB = (m + 1) % MAX_PICK;
    mwss_cell #(.CW(CW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_int),
      .ld_i       (ld_en[m]),
      .init_val_i (CW'(m)),
      .init_act_i (CMPW'(m) < k_cfg),
      .ld_val_i   (ld_val),
      .nb_city_i  (city[NB]),
      .nb_act_i   (act[NB]),
      .nb_col_i   (col[NB]),
      .nb_cact_i  (cact[NB]),
      .city_o     (city[m]),
      .act_o      (act[m]),
      .col_o      (col[m]),
      .cact_o     (cact[m])
    );
  end

  assign in_i.ready  = (state_q == mwss_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign wr_en       = in_acc && (in_i.func == mwss_pkg::FUNC_WRITE) &&
                       (32'(in_i.row) < MAX_CITIES) && (32'(in_i.col) < MAX_CITIES);
  assign srch        = in_acc && (in_i.func == mwss_pkg::FUNC_SEARCH);

  assign k_cfg     = CMPW'(pick_cnt_q);
  assign n_eff     = (CMPW'(city_cnt_q) > CMPW'(MAX_CITIES)) ? CMPW'(MAX_CITIES)
                                                             : CMPW'(city_cnt_q);
  assign no_choice = (k_cfg == '0) || (k_cfg > n_eff) || (k_cfg > CMPW'(MAX_PICK));

  assign acc_ext  = EW'(acc_q);
  assign sat      = (acc_ext > EW'(mwss_pkg::SUM_LIMIT)) ? mwss_pkg::SUM_LIMIT
                                                         : mwss_pkg::BEST_W'(acc_ext);
  assign sel_city = city[rd_idx];
  assign limit    = SW'(n_q) - SW'(k_q) + SW'(ptr_q);

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    k_d       = k_q;
    rstep_d   = rstep_q;
    cstep_d   = cstep_q;
    ptr_d     = ptr_q;
    acc_d     = acc_q;
    best_d    = best_q;
    any_d     = any_q;
    rd_v_d    = 1'b0;
    out_vld_d = out_vld_q;
    out_sum_d = out_sum_q;
    out_fnd_d = out_fnd_q;
    ctl       = '0;
    ld_en     = '0;
    ld_val    = sel_city + CW'(1);
    rd_idx    = ptr_q[PW-1:0];

    if (rd_v_q) begin
      acc_d = acc_q + AW'(rdata_q);
    end
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      mwss_pkg::ST_IDLE: begin
        if (srch) begin
          any_d  = 1'b0;
          best_d = '0;
          acc_d  = '0;
          if (no_choice) begin
            state_d = mwss_pkg::ST_DONE;
          end else begin
            n_d     = CNW'(n_eff);
            k_d     = KW'(k_cfg);
            rstep_d = '0;
            state_d = mwss_pkg::ST_INC;
            ptr_d   = '0;
          end
        end
      end
      mwss_pkg::ST_INC: begin
        ld_en[ptr_q[PW-1:0]] = 1'b1;
        ptr_d = ptr_q + KW'(1);
        if (ptr_q + KW'(1) == k_q) begin
          state_d = mwss_pkg::ST_ROW;
        end else begin
          state_d = mwss_pkg::ST_FILL;
        end
      end
      mwss_pkg::ST_FILL: begin
        rd_idx = PW'(ptr_q - KW'(1));
        ld_en[ptr_q[PW-1:0]] = 1'b1;
        if (ptr_q == k_q - KW'(1)) begin
          state_d = mwss_pkg::ST_ROW;
        end else begin
          ptr_d = ptr_q + KW'(1);
        end
      end
      mwss_pkg::ST_ROW: begin
        if (act[0]) begin
          ctl.ccopy = 1'b1;
          cstep_d   = '0;
          state_d   = mwss_pkg::ST_COL;
        end else begin
          state_d = mwss_pkg::ST_ROWNXT;
        end
      end
      mwss_pkg::ST_COL: begin
        rd_v_d   = (cstep_q != '0) && act[0] && cact[0];
        ctl.crot = 1'b1;
        if (cstep_q == KW'(MAX_PICK - 1)) begin
          state_d = mwss_pkg::ST_ROWNXT;
        end else begin
          cstep_d = cstep_q + KW'(1);
        end
      end
      mwss_pkg::ST_ROWNXT: begin
        ctl.rot = 1'b1;
        if (rstep_q == KW'(MAX_PICK - 1)) begin
          rstep_d = '0;
          state_d = mwss_pkg::ST_EVAL;
        end else begin
          rstep_d = rstep_q + KW'(1);
          state_d = mwss_pkg::ST_ROW;
        end
      end
      mwss_pkg::ST_EVAL: begin
        if (!any_q || sat > best_q) begin
          best_d = sat;
        end
        any_d   = 1'b1;
        acc_d   = '0;
        ptr_d   = k_q - KW'(1);
        state_d = mwss_pkg::ST_SCAN;
      end
      mwss_pkg::ST_SCAN: begin
        if (SW'(sel_city) < limit) begin
          state_d = mwss_pkg::ST_INC;
        end else if (ptr_q == '0) begin
          state_d = mwss_pkg::ST_DONE;
        end else begin
          ptr_d = ptr_q - KW'(1);
        end
      end
      mwss_pkg::ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_fnd_d = any_q;
          out_sum_d = any_q ? $signed({1'b0, best_q}) : $signed(mwss_pkg::NO_SUM);
          state_d   = mwss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mwss_pkg::ST_IDLE;
      end
    endcase

    // first entry after a search start loads the starting choice
    if (state_q == mwss_pkg::ST_IDLE && srch && !no_choice) begin
      state_d = mwss_pkg::ST_ROW;
    end
  end

  // load the first choice while entering the row pass from idle
  assign init_go = (state_q == mwss_pkg::ST_IDLE) && srch && !no_choice;

  always_comb begin
    ctl_int      = ctl;
    ctl_int.init = init_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mwss_pkg::ST_IDLE;
      city_cnt_q <= mwss_pkg::CFG_DAT_W'(16);
      pick_cnt_q <= mwss_pkg::CFG_DAT_W'(2);
      n_q        <= '0;
      k_q        <= '0;
      rstep_q    <= '0;
      cstep_q    <= '0;
      ptr_q      <= '0;
      acc_q      <= '0;
      best_q     <= '0;
      any_q      <= 1'b0;
      rd_v_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      out_fnd_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      k_q       <= init_go ? KW'(k_cfg) : k_d;
      rstep_q   <= rstep_d;
      cstep_q   <= cstep_d;
      ptr_q     <= ptr_d;
      acc_q     <= acc_d;
      best_q    <= best_d;
      any_q     <= any_d;
      rd_v_q    <= rd_v_d;
      out_vld_q <= out_vld_d;
      out_fnd_q <= out_fnd_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == mwss_pkg::CFG_CITY_COUNT) begin
          city_cnt_q <= cfg_i.data;
        end else if (cfg_i.index == mwss_pkg::CFG_PICK_COUNT) begin
          pick_cnt_q <= cfg_i.data;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_sum_q <= out_sum_d;
    rdata_q   <= mem_q[city[0]][col[0]];
    if (wr_en) begin
      mem_q[CW'(in_i.row)][CW'(in_i.col)] <= WEIGHT_BITS'(in_i.weight);
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.best_sum = out_sum_q;
  assign out_o.found    = out_fnd_q;

endmodule

// ===== rtl/mwss_checker.sv =====
`include "assert_macros.svh"

module mwss_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_func,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mwss_pkg::SUM_W-1:0] out_best_sum,
  input logic                              out_found
);

  `MWSS_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid)
  `MWSS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `MWSS_ASSERT(a_search_busy, in_valid && in_ready && in_func == mwss_pkg::FUNC_SEARCH |=> !in_ready)
  `MWSS_ASSERT(a_result_after_busy, $rose(out_valid) |-> !$past(in_ready))
  `MWSS_ASSERT(a_none_sum, out_valid && !out_found |-> out_best_sum == mwss_pkg::NO_SUM)

endmodule

bind max_weight_subset_search mwss_checker u_mwss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_func      (in_i.func),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_best_sum (out_o.best_sum),
  .out_found    (out_o.found)
);
